[sv/mvs_pkg.sv]
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types and constants of the multichannel volume scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package mvs_pkg;

  localparam int unsigned MAX_CHANNELS    = 8;
  localparam int unsigned CHAN_W          = $clog2(MAX_CHANNELS);
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned GAIN_W          = 16;
  localparam int unsigned LAYOUT_W        = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;

  typedef enum logic [LAYOUT_W-1:0] {
    LAYOUT_MONO    = 2'd0,
    LAYOUT_STEREO  = 2'd1,
    LAYOUT_EIGHT   = 2'd2,
    LAYOUT_EIGHT_STD = 2'd3
  } layout_t;

  localparam layout_t LAYOUT_RESET = LAYOUT_STEREO;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_VOLUME = 1'b1
  } command_t;

  localparam logic REG_LAYOUT = 1'b0;

  typedef struct packed {
    logic                          en;
    logic [LAYOUT_W-1:0]           layout;
  } cfg_write_t;

  typedef struct packed {
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] samples;
    logic [MAX_CHANNELS-1:0][GAIN_W-1:0]   gains;
    logic [CHAN_W-1:0]                     last_chan;
    logic                                  std_order;
  } frame_entry_t;

  // standard eight channel reorder, its own inverse
  function automatic logic [CHAN_W-1:0] std_map(input logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] r;
    begin
      case (c)
        3'd4:    r = 3'd6;
        3'd5:    r = 3'd7;
        3'd6:    r = 3'd4;
        3'd7:    r = 3'd5;
        default: r = c;
      endcase
      return r;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] layout_last(input logic [LAYOUT_W-1:0] l);
    logic [CHAN_W-1:0] r;
    begin
      case (l)
        LAYOUT_MONO:   r = 3'd0;
        LAYOUT_STEREO: r = 3'd1;
        default:       r = CHAN_W'(MAX_CHANNELS - 1);
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

[sv/mvs_front.sv]
// ----------------------------------------------------------------------------
// mvs_front
// Accepts transactions, keeps layout, gains and the partial frame, and
// pushes a complete frame snapshot into the frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mvs_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mvs_pkg::cfg_write_t          cfg_wr,
  output logic [mvs_pkg::LAYOUT_W-1:0]      layout,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         command,
  input  wire logic signed [15:0]           sample_in,
  input  wire logic [2:0]                   volume_slot,
  input  wire logic [15:0]                  volume_value,
  input  wire logic                         q_full,
  output logic                              q_push,
  output mvs_pkg::frame_entry_t             q_data
);
  import mvs_pkg::*;

  logic [MAX_CHANNELS-1:0][GAIN_W-1:0]   gains;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] store;
  logic [CHAN_W-1:0]                     fill;
  logic [CHAN_W-1:0]                     last_chan;
  logic                                  is_std;
  logic                                  accept;
  logic                                  is_sample;
  logic                                  completes;
  logic [CHAN_W-1:0]                     vol_chan;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_sample = (command == CMD_SAMPLE);
  assign last_chan = layout_last(layout);
  assign is_std    = (layout == LAYOUT_EIGHT_STD);
  assign completes = (fill == last_chan);
  assign vol_chan  = is_std ? std_map(volume_slot) : volume_slot;
  assign q_push    = accept && is_sample && completes;

  always_comb begin
    q_data.samples       = store;
    q_data.samples[fill] = sample_in;
    q_data.gains         = gains;
    q_data.last_chan     = last_chan;
    q_data.std_order     = is_std;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= LAYOUT_RESET;
      fill   <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        gains[i] <= UNITY_GAIN;
      end
    end else if (cfg_wr.en) begin
      layout <= cfg_wr.layout;
      fill   <= '0;
    end else if (accept) begin
      if (is_sample) begin
        fill <= completes ? '0 : fill + 1'b1;
      end else if (vol_chan <= last_chan) begin
        gains[vol_chan] <= volume_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sample) begin
      store[fill] <= sample_in;
    end
  end

endmodule

`default_nettype wire

[sv/mvs_frame_queue.sv]
// ----------------------------------------------------------------------------
// mvs_frame_queue
// Short queue of complete frame snapshots between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mvs_frame_queue #(
  parameter int unsigned QUEUE_DEPTH = mvs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire mvs_pkg::frame_entry_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output mvs_pkg::frame_entry_t      head_data
);
  import mvs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_entry_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/mvs_back.sv]
// ----------------------------------------------------------------------------
// mvs_back
// Walks the channels of the head frame, multiplies by the gain, scales by
// 1/32768 toward zero and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvs_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire mvs_pkg::frame_entry_t head_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [15:0]         sample_out,
  output logic [2:0]                 out_channel,
  output logic                       frame_last
);
  import mvs_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned QUO_W  = PROD_W - 15;

  logic [CHAN_W-1:0]        chan;
  logic [CHAN_W-1:0]        src;
  logic                     out_adv;
  logic                     issue;
  logic                     is_last;

  logic                     p_valid;
  logic signed [PROD_W-1:0] p_prod;
  logic [CHAN_W-1:0]        p_chan;
  logic                     p_last;

  logic signed [PROD_W-1:0] biased;
  logic signed [QUO_W-1:0]  quo;
  logic signed [15:0]       sat;

  assign out_adv = !out_valid || out_ready;
  assign issue   = head_valid && (!p_valid || out_adv);
  assign is_last = (chan == head_data.last_chan);
  assign pop     = issue && is_last;
  assign src     = head_data.std_order ? std_map(chan) : chan;

  // truncation toward zero: bias negative products before the shift
  assign biased = p_prod + (p_prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
  assign quo    = biased[PROD_W-1:15];

  always_comb begin
    if (quo > QUO_W'(32767)) begin
      sat = 16'sd32767;
    end else if (quo < -QUO_W'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan      <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        chan <= is_last ? '0 : chan + 1'b1;
      end
      if (issue) begin
        p_valid <= 1'b1;
      end else if (out_adv) begin
        p_valid <= 1'b0;
      end
      if (out_adv) begin
        out_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_prod <= $signed(head_data.samples[src]) * $signed({1'b0, head_data.gains[chan]});
      p_chan <= chan;
      p_last <= is_last;
    end
    if (out_adv && p_valid) begin
      sample_out  <= sat;
      out_channel <= p_chan;
      frame_last  <= p_last;
    end
  end

endmodule

`default_nettype wire

[sv/multichannel_volume_scaler.sv]
// ----------------------------------------------------------------------------
// multichannel_volume_scaler
// Collects interleaved pcm frames, applies per-channel gain with saturation.
//
//   channel   signals                                    role
//   input     in_valid/in_ready, command, sample_in,     sample or volume write
//             volume_slot, volume_value
//   output    out_valid/out_ready, sample_out,           one scaled channel
//             out_channel, frame_last
//   config    psel/penable/pwrite/paddr/pwdata/prdata    channel_layout at 0x0
//
// one input transaction per cycle while the frame queue has room
// a frame of n channels leaves as n output transactions, one per cycle
// while out_ready holds, via the product and output registers (multiply,
// then scale), the back end issuing one per cycle on its single multiplier
// reset: synchronous, layout stereo, every gain unity, no partial frame
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_volume_scaler #(
  parameter int unsigned QUEUE_DEPTH = mvs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mvs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mvs_pkg::PDATA_W-1:0]  pwdata,
  output logic [mvs_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         command,
  input  wire logic signed [15:0]           sample_in,
  input  wire logic [2:0]                   volume_slot,
  input  wire logic [15:0]                  volume_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [15:0]                sample_out,
  output logic [2:0]                        out_channel,
  output logic                              frame_last
);
  import mvs_pkg::*;

  cfg_write_t          cfg_wr;
  logic [LAYOUT_W-1:0] layout;
  logic                q_full;
  logic                q_push;
  frame_entry_t        q_push_data;
  logic                q_pop;
  logic                q_head_valid;
  frame_entry_t        q_head_data;
  logic                reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1];
  assign cfg_wr.en = psel && penable && pwrite && pready && (reg_sel == REG_LAYOUT);
  assign cfg_wr.layout = pwdata[LAYOUT_W-1:0];

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_LAYOUT) begin
      prdata = PDATA_W'(layout);
    end
  end

  mvs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg_wr),
    .layout       (layout),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .sample_in    (sample_in),
    .volume_slot  (volume_slot),
    .volume_value (volume_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_push_data)
  );

  mvs_frame_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  mvs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head_data   (q_head_data),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .out_channel (out_channel),
    .frame_last  (frame_last)
  );

endmodule

`default_nettype wire
